[rtl/frws_pkg.sv]
package frws_pkg;

   localparam int WORD_INDEX_W = 10;
   localparam int OFFSET_W     = 8;
   localparam int COUNT_W      = 8;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 10;

   localparam logic [COUNT_W-1:0] FAULT_WORDS_RESET = 8'd16;
   localparam logic [COUNT_W-1:0] VIN_WORDS         = 8'd5;
   localparam logic [COUNT_W-1:0] SERIAL_WORDS      = 8'd4;

   // Marker data word itself is supplied by the data mux downstream (source MARKER).
   localparam logic [31:0] MARKER_WORD = 32'h1234_5678;

   typedef enum logic [0:0] {
      CMD_START = 1'b0,
      CMD_STEP  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      JOB_FAULT  = 2'd0,
      JOB_VIN    = 2'd1,
      JOB_SERIAL = 2'd2,
      JOB_NONE   = 2'd3
   } job_type;

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_ERASE = 2'd1,
      OP_WRITE = 2'd2,
      OP_RSVD  = 2'd3
   } flash_op_type;

   typedef enum logic [1:0] {
      SRC_FAULT  = 2'd0,
      SRC_SERIAL = 2'd1,
      SRC_VIN    = 2'd2,
      SRC_MARKER = 2'd3
   } source_type;

   localparam logic [1:0] BLOCK_FAULT  = 2'd0;
   localparam logic [1:0] BLOCK_SERIAL = 2'd1;
   localparam logic [1:0] BLOCK_VIN    = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_FAULT_WORDS  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VIN_START    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SERIAL_START = 2'd2;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_ERASE = 3'b010,
      PH_WRITE = 3'b100
   } phase_type;

   typedef struct packed {
      logic       cmd;
      logic [1:0] job_kind;
      logic       erase_done;
      logic       write_done;
   } req_type;

   typedef struct packed {
      logic [1:0]              flash_op;
      logic [1:0]              block_index;
      logic [WORD_INDEX_W-1:0] word_index;
      logic [1:0]              source_select;
      logic [OFFSET_W-1:0]     source_offset;
      logic                    busy_res;
      logic                    job_finished;
      logic                    start_ignored;
   } rsp_type;

   typedef struct packed {
      logic [COUNT_W-1:0]      fault_table_words;
      logic [WORD_INDEX_W-1:0] vin_start_index;
      logic [WORD_INDEX_W-1:0] serial_start_index;
   } cfg_type;

   typedef struct packed {
      phase_type               phase;
      logic [1:0]              active_job;
      logic [1:0]              erase_block;
      logic [WORD_INDEX_W-1:0] next_word_index;
      logic [COUNT_W-1:0]      words_left;
      logic [1:0]              data_source;
      logic [OFFSET_W-1:0]     data_offset;
      logic                    marker_written;
   } state_type;

endpackage

[rtl/flash_record_write_sequencer.sv]
// Data-flash record update sequencer. A start transaction (cmd 0) loads one of three jobs
// (fault table, VIN, serial number); each following step transaction (cmd 1) returns the
// flash operation to issue: an erase of the job's block until erase_done, then one word
// write per step, advancing word index and source offset on write_done. The fault-table
// job appends a marker word (source 3) at the next index. Every request yields exactly one
// response, in the cycle after it is taken; a request can be taken every cycle, and the
// request side stalls only while a held response is itself stalled. Word indexes wrap at
// 1024. Registers are sampled at job start; csr_ready is always high.
module flash_record_write_sequencer
   import frws_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   state_type state_ff, state_in;
   state_type state_next;
   rsp_type   rsp_ff, rsp_in, rsp_next;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_take;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   frws_step u_step (
      .state      (state_ff),
      .cfg        (cfg_ff),
      .req        (req_data),
      .state_next (state_next),
      .rsp        (rsp_next)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FAULT_WORDS:  cfg_in.fault_table_words  = csr_wdata[COUNT_W-1:0];
            CSR_VIN_START:    cfg_in.vin_start_index    = csr_wdata[WORD_INDEX_W-1:0];
            CSR_SERIAL_START: cfg_in.serial_start_index = csr_wdata[WORD_INDEX_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      state_in     = req_take ? state_next : state_ff;
      rsp_in       = req_take ? rsp_next : rsp_ff;
      rsp_valid_in = req_take || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{fault_table_words: FAULT_WORDS_RESET,
                           vin_start_index: '0, serial_start_index: '0};
         state_ff     <= '{phase: PH_IDLE, active_job: '0, erase_block: '0,
                           next_word_index: '0, words_left: COUNT_W'(1),
                           data_source: '0, data_offset: '0, marker_written: 1'b0};
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_take_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_finish_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.job_finished |-> !rsp_ff.busy_res && rsp_ff.flash_op == OP_WRITE)
      else $error("finished job still busy or not on a write");

   a_ignored_no_op: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.start_ignored |-> rsp_ff.flash_op == OP_NONE && rsp_ff.busy_res)
      else $error("dropped start issued an operation or left busy");

   a_marker_offset: assert property (@(posedge clock) disable iff (reset)
      state_ff.data_source == SRC_MARKER |-> state_ff.data_offset == '0 &&
         state_ff.marker_written && state_ff.active_job == JOB_FAULT)
      else $error("marker source in an inconsistent job state");

endmodule

[rtl/frws_step.sv]
module frws_step
   import frws_pkg::*;
(
   input  state_type state,
   input  cfg_type   cfg,
   input  req_type   req,
   output state_type state_next,
   output rsp_type   rsp
);

   logic               busy;
   logic [COUNT_W-1:0] left_dec;

   assign busy     = (state.phase == PH_ERASE) || (state.phase == PH_WRITE);
   assign left_dec = state.words_left - 1'b1;

   always_comb begin
      state_next = state;
      rsp        = '0;

      if (req.cmd == CMD_START) begin
         if (busy) begin
            rsp.start_ignored = 1'b1;
         end else if (req.job_kind != JOB_NONE) begin
            state_next.active_job     = req.job_kind;
            state_next.data_offset    = '0;
            state_next.marker_written = 1'b0;
            state_next.phase          = PH_ERASE;
            unique case (req.job_kind)
               JOB_FAULT: begin
                  state_next.erase_block     = BLOCK_FAULT;
                  state_next.next_word_index = '0;
                  // empty table still gets one word
                  state_next.words_left      = (cfg.fault_table_words == '0) ?
                                               COUNT_W'(1) : cfg.fault_table_words;
                  state_next.data_source     = SRC_FAULT;
               end
               JOB_VIN: begin
                  state_next.erase_block     = BLOCK_VIN;
                  state_next.next_word_index = cfg.vin_start_index;
                  state_next.words_left      = VIN_WORDS;
                  state_next.data_source     = SRC_VIN;
               end
               default: begin
                  state_next.erase_block     = BLOCK_SERIAL;
                  state_next.next_word_index = cfg.serial_start_index;
                  state_next.words_left      = SERIAL_WORDS;
                  state_next.data_source     = SRC_SERIAL;
               end
            endcase
         end
      end else begin
         unique case (state.phase)
            PH_ERASE: begin
               rsp.flash_op    = OP_ERASE;
               rsp.block_index = state.erase_block;
               if (req.erase_done) begin
                  state_next.phase = PH_WRITE;
               end
            end
            PH_WRITE: begin
               rsp.flash_op      = OP_WRITE;
               rsp.word_index    = state.next_word_index;
               rsp.source_select = state.data_source;
               rsp.source_offset = state.data_offset;
               if (req.write_done) begin
                  state_next.words_left = left_dec;
                  if (left_dec != '0) begin
                     state_next.next_word_index = state.next_word_index + 1'b1;
                     state_next.data_offset     = state.data_offset + 1'b1;
                  end else if (state.active_job == JOB_FAULT && !state.marker_written) begin
                     state_next.next_word_index = state.next_word_index + 1'b1;
                     state_next.words_left      = COUNT_W'(1);
                     state_next.data_source     = SRC_MARKER;
                     state_next.data_offset     = '0;
                     state_next.marker_written  = 1'b1;
                  end else begin
                     state_next.phase = PH_IDLE;
                     rsp.job_finished = 1'b1;
                  end
               end
            end
            default: begin
               state_next.phase = PH_IDLE;
            end
         endcase
      end

      rsp.busy_res = (state_next.phase == PH_ERASE) || (state_next.phase == PH_WRITE);
   end

endmodule

[verif/testbench.sv]
module testbench
   import frws_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;
   localparam int WATCHDOG_LIMIT = 3000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   flash_record_write_sequencer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   req_type request_backlog[$];
   rsp_type predicted_ops[$];
   int      items_made = 0;
   int      errors = 0;
   int      responses_seen = 0;
   int      idle_cycles = 0;

   // register copies, as the block sees them
   logic [COUNT_W-1:0]      cfg_fault_words = FAULT_WORDS_RESET;
   logic [WORD_INDEX_W-1:0] cfg_vin_start = '0;
   logic [WORD_INDEX_W-1:0] cfg_serial_start = '0;

   // sequencer state
   phase_type               seq_phase = PH_IDLE;
   job_type                 seq_job = JOB_FAULT;
   logic [1:0]              seq_block = '0;
   logic [WORD_INDEX_W-1:0] seq_word = '0;
   logic [COUNT_W-1:0]      seq_left = 8'd1;
   source_type              seq_src = SRC_FAULT;
   logic [OFFSET_W-1:0]     seq_offset = '0;
   logic                    seq_marker_done = 1'b0;

   function automatic rsp_type sequence_flash_op(req_type r);
      rsp_type o;
      o = '0;
      if (r.cmd == CMD_START) begin
         if (seq_phase != PH_IDLE) begin
            o.start_ignored = 1'b1;
         end else if (job_type'(r.job_kind) != JOB_NONE) begin
            seq_job = job_type'(r.job_kind);
            seq_offset = '0;
            seq_marker_done = 1'b0;
            case (seq_job)
               JOB_FAULT: begin
                  seq_block = BLOCK_FAULT;
                  seq_word = '0;
                  seq_left = (cfg_fault_words == '0) ? 8'd1 : cfg_fault_words;
                  seq_src = SRC_FAULT;
               end
               JOB_VIN: begin
                  seq_block = BLOCK_VIN;
                  seq_word = cfg_vin_start;
                  seq_left = VIN_WORDS;
                  seq_src = SRC_VIN;
               end
               default: begin
                  seq_block = BLOCK_SERIAL;
                  seq_word = cfg_serial_start;
                  seq_left = SERIAL_WORDS;
                  seq_src = SRC_SERIAL;
               end
            endcase
            seq_phase = PH_ERASE;
         end
      end else if (seq_phase == PH_ERASE) begin
         o.flash_op = OP_ERASE;
         o.block_index = seq_block;
         if (r.erase_done) seq_phase = PH_WRITE;
      end else if (seq_phase == PH_WRITE) begin
         o.flash_op = OP_WRITE;
         o.word_index = seq_word;
         o.source_select = seq_src;
         o.source_offset = seq_offset;
         if (r.write_done) begin
            seq_left = seq_left - 1'b1;
            if (seq_left != '0) begin
               seq_word = seq_word + 1'b1;
               seq_offset = seq_offset + 1'b1;
            end else if (seq_job == JOB_FAULT && !seq_marker_done) begin
               // fault table gets its trailing marker word at the next index
               seq_word = seq_word + 1'b1;
               seq_left = 8'd1;
               seq_src = SRC_MARKER;
               seq_offset = '0;
               seq_marker_done = 1'b1;
            end else begin
               seq_phase = PH_IDLE;
               o.job_finished = 1'b1;
            end
         end
      end
      o.busy_res = (seq_phase != PH_IDLE);
      return o;
   endfunction

   function automatic void note_error(string msg);
      errors++;
      $display("%s", msg);
   endfunction

   function automatic void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got)
         note_error($sformatf("%0t ns: %s expected %0d, got %0d", $time, name, want, got));
   endfunction

   function automatic void queue_item(cmd_type c, job_type k, int unsigned ed,
                                      int unsigned wd);
      req_type r;
      r.cmd = c;
      r.job_kind = k;
      r.erase_done = ed[0];
      r.write_done = wd[0];
      request_backlog.push_back(r);
      items_made++;
   endfunction

   function automatic job_type any_kind();
      return job_type'($urandom_range(0, 3));
   endfunction

   // well-formed job: start, erase until done, then every word with random done delays
   function automatic void queue_job(job_type kind);
      int words;
      case (kind)
         JOB_FAULT: words = ((cfg_fault_words == '0) ? 1 : int'(cfg_fault_words)) + 1;
         JOB_VIN:   words = int'(VIN_WORDS);
         default:   words = int'(SERIAL_WORDS);
      endcase
      queue_item(CMD_START, kind, $urandom_range(0, 1), $urandom_range(0, 1));
      repeat ($urandom_range(0, 3)) queue_item(CMD_STEP, any_kind(), 1'b0, $urandom_range(0, 1));
      if ($urandom_range(0, 4) == 0) queue_item(CMD_START, any_kind(), 1'b1, 1'b1);
      queue_item(CMD_STEP, any_kind(), 1'b1, $urandom_range(0, 1));
      for (int w = 0; w < words; w++) begin
         while ($urandom_range(0, 3) == 0)
            queue_item(CMD_STEP, any_kind(), $urandom_range(0, 1), 1'b0);
         if ($urandom_range(0, 19) == 0)
            queue_item(CMD_START, any_kind(), $urandom_range(0, 1), $urandom_range(0, 1));
         queue_item(CMD_STEP, any_kind(), $urandom_range(0, 1), 1'b1);
      end
   endfunction

   function automatic void queue_random_traffic(int target);
      int      first;
      bit      long_table;
      job_type kind;
      first = items_made;
      long_table = (cfg_fault_words > 8'd16);
      if (long_table) queue_job(JOB_FAULT);
      while (items_made - first < target) begin
         if ($urandom_range(0, 9) < 8) begin
            kind = job_type'($urandom_range(0, 2));
            if (long_table && kind == JOB_FAULT) kind = JOB_SERIAL;
            queue_job(kind);
            if ($urandom_range(0, 3) == 0)
               queue_item(CMD_STEP, any_kind(), $urandom_range(0, 1), $urandom_range(0, 1));
         end else begin
            repeat ($urandom_range(1, 4))
               queue_item(cmd_type'($urandom_range(0, 1)), any_kind(),
                          $urandom_range(0, 1), $urandom_range(0, 1));
         end
      end
   endfunction

   task automatic wait_drained();
      do @(posedge clock);
      while (request_backlog.size() != 0 || req_valid || predicted_ops.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_registers(input logic [CSR_DATA_W-1:0] fault_words,
                                    input logic [CSR_DATA_W-1:0] vin_start,
                                    input logic [CSR_DATA_W-1:0] serial_start,
                                    input bit touch_spare);
      logic [CSR_DATA_W-1:0] value;
      logic [CSR_INDEX_W-1:0] idx;
      for (int i = 0; i <= (touch_spare ? int'(CSR_SPARE) : int'(CSR_SERIAL_START)); i++) begin
         idx = CSR_INDEX_W'(i);
         case (idx)
            CSR_FAULT_WORDS: value = fault_words;
            CSR_VIN_START:   value = vin_start;
            CSR_SERIAL_START: value = serial_start;
            default:         value = CSR_DATA_W'($urandom_range(0, 1023));
         endcase
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_wdata <= value;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         case (idx)
            CSR_FAULT_WORDS:  cfg_fault_words = value[COUNT_W-1:0];
            CSR_VIN_START:    cfg_vin_start = value[WORD_INDEX_W-1:0];
            CSR_SERIAL_START: cfg_serial_start = value[WORD_INDEX_W-1:0];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_start_index();
      if ($urandom_range(0, 1) == 0) return CSR_DATA_W'($urandom_range(1016, 1023));
      return CSR_DATA_W'($urandom_range(0, 1023));
   endfunction

   // request driver
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) predicted_ops.push_back(sequence_flash_op(req_data));
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (request_backlog.size() != 0) begin
               req_valid <= 1'b1;
               req_data <= request_backlog.pop_front();
               if (burst_left > 1) begin
                  burst_left--;
               end else if ($urandom_range(0, 3) == 0) begin
                  burst_left = $urandom_range(40, 120);
                  gap_left = 0;
               end else begin
                  burst_left = $urandom_range(1, 16);
                  gap_left = $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and receiver stall pattern
   int      hold_left = 0;
   int      mode_left = 0;
   int      stall_mode = 0;
   rsp_type want;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            responses_seen++;
            if (predicted_ops.size() == 0) begin
               note_error($sformatf("%0t ns: unexpected transaction, expected none, got %h",
                                    $time, rsp_data));
            end else begin
               want = predicted_ops.pop_front();
               compare_field("flash_op", want.flash_op, rsp_data.flash_op);
               compare_field("block_index", want.block_index, rsp_data.block_index);
               compare_field("word_index", want.word_index, rsp_data.word_index);
               compare_field("source_select", want.source_select, rsp_data.source_select);
               compare_field("source_offset", want.source_offset, rsp_data.source_offset);
               compare_field("busy_res", want.busy_res, rsp_data.busy_res);
               compare_field("job_finished", want.job_finished, rsp_data.job_finished);
               compare_field("start_ignored", want.start_ignored, rsp_data.start_ignored);
            end
            // long back-pressure so the request side backs up
            if (responses_seen == 300 || responses_seen == 800) hold_left = 200;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 120);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 99) < 30);
               2: rsp_stall <= ($urandom_range(0, 99) < 70);
               default: rsp_stall <= !rsp_stall;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("%0t ns: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      logic [CSR_DATA_W-1:0] fw;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings: idle step, dropped starts, VIN job with stray done flags
      queue_item(CMD_STEP, JOB_NONE, 1'b1, 1'b1);
      queue_item(CMD_START, JOB_NONE, 1'b0, 1'b0);
      queue_item(CMD_START, JOB_VIN, 1'b1, 1'b1);
      queue_item(CMD_STEP, JOB_FAULT, 1'b0, 1'b1);
      queue_item(CMD_START, JOB_SERIAL, 1'b0, 1'b0);
      queue_item(CMD_STEP, JOB_FAULT, 1'b1, 1'b0);
      queue_item(CMD_STEP, JOB_NONE, 1'b1, 1'b0);
      repeat (5) queue_item(CMD_STEP, JOB_FAULT, 1'b0, 1'b1);
      queue_item(CMD_STEP, JOB_FAULT, 1'b0, 1'b0);
      wait_drained();

      // zero-length table counts as one word; serial index wraps past the top
      program_registers(10'h300, 10'd1021, 10'd1023, 1'b1);
      queue_item(CMD_START, JOB_FAULT, 1'b0, 1'b0);
      queue_item(CMD_STEP, JOB_FAULT, 1'b1, 1'b1);
      queue_item(CMD_STEP, JOB_FAULT, 1'b0, 1'b1);
      queue_item(CMD_STEP, JOB_FAULT, 1'b0, 1'b1);
      queue_item(CMD_START, JOB_SERIAL, 1'b0, 1'b0);
      queue_item(CMD_STEP, JOB_SERIAL, 1'b1, 1'b0);
      repeat (4) queue_item(CMD_STEP, JOB_SERIAL, 1'b0, 1'b1);
      wait_drained();

      program_registers(10'h0FF, 10'd0, 10'd1023, 1'b0);
      queue_random_traffic(420);
      wait_drained();

      program_registers(10'h101, 10'd1023, 10'd0, 1'b1);
      queue_random_traffic(150);
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         fw = CSR_DATA_W'($urandom_range(0, 12));
         fw[CSR_DATA_W-1:COUNT_W] = (CSR_DATA_W-COUNT_W)'($urandom_range(0, 3));
         program_registers(fw, pick_start_index(), pick_start_index(), p[0]);
         queue_random_traffic(150);
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (predicted_ops.size() != 0)
         note_error($sformatf("%0t ns: %0d transactions expected, got none",
                              $time, predicted_ops.size()));
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

[flash_record_write_sequencer.f]
rtl/frws_pkg.sv
rtl/frws_step.sv
rtl/flash_record_write_sequencer.sv
verif/testbench.sv
